[design/assert_macros.svh]
// Assertion macros used by the checker file.
// Each macro samples on posedge clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General clocked property.
`define TCW_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that only applies while a result is offered on the output channel.
`define TCW_ASSERT_RSP(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) rsp_valid |-> (cond)) \
        else $error(msg);

`endif

[design/tcw_pkg.sv]
// Shared constants, codes and types of the text console writer.
// No dependencies; the design files that use it refer to it by scoped names.
package tcw_pkg;

    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int TAB_STOP      = 8;   // power of two: offset phase is a mask

    localparam int NUM_CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int LAST_ROW  = (SCREEN_HEIGHT - 1) * SCREEN_WIDTH;

    localparam int ADDR_W = $clog2(NUM_CELLS);
    localparam int SUM_W  = ADDR_W + 1;
    localparam int COL_W  = $clog2(SCREEN_WIDTH);
    localparam int ROW_W  = $clog2(SCREEN_HEIGHT);

    localparam int FUNC_W = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CX_W   = 7;
    localparam int CY_W   = 5;
    localparam int ROFF_W = 11;
    localparam int POS_W  = 11;
    localparam int CELL_W = CHAR_W + ATTR_W;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CODE_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_SPACE   = 8'd32;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_SET   = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_READ  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        OP_CHAR,
        OP_NEWLINE,
        OP_TAB,
        OP_SET,
        OP_CLEAR,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [CHAR_W-1:0]  ch;
        logic [ATTR_W-1:0]  attr;
        logic [COL_W-1:0]   col;
        logic [ADDR_W-1:0]  row_start;
        logic [ADDR_W-1:0]  raddr;
        logic               rd_ok;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_slot_t;

    typedef struct packed {
        logic init_busy;
    } back_status_t;

endpackage

[design/tcw_if.sv]
// Handshake channels of the text console writer: request and response.
// Depends on tcw_pkg for field widths.
interface tcw_in_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::FUNC_W-1:0]    func;
    logic [tcw_pkg::CHAR_W-1:0]    char_code;
    logic [tcw_pkg::ATTR_W-1:0]    color;
    logic [tcw_pkg::CX_W-1:0]      cursor_x;
    logic [tcw_pkg::CY_W-1:0]      cursor_y;
    logic [tcw_pkg::ROFF_W-1:0]    read_offset;

    modport source (output valid, func, char_code, color, cursor_x, cursor_y, read_offset,
                    input ready);
    modport sink   (input valid, func, char_code, color, cursor_x, cursor_y, read_offset,
                    output ready);
endinterface

interface tcw_out_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::POS_W-1:0]     cursor_position;
    logic [tcw_pkg::CHAR_W-1:0]    read_char;
    logic [tcw_pkg::ATTR_W-1:0]    read_attr;
    logic                          scrolled;

    modport source (output valid, cursor_position, read_char, read_attr, scrolled,
                    input ready);
    modport sink   (input valid, cursor_position, read_char, read_attr, scrolled,
                    output ready);
endinterface

[design/tcw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/tcw_front.sv]
// Front end: takes request transfers and turns them into decoded commands.
// Depends on tcw_pkg and tcw_in_if.
module tcw_front (
    tcw_in_if.sink                  req,
    input  logic                    queue_full,
    input  tcw_pkg::back_status_t   back_status,
    output tcw_pkg::cmd_slot_t      push
);

    tcw_pkg::cmd_t                  cmd;
    logic [tcw_pkg::ROW_W-1:0]      row_sat;

    // Hold off requests while the queue is full or the screen store is being cleared after reset.
    assign req.ready = !queue_full && !back_status.init_busy;

    always_comb
    begin
        cmd = '0;
        cmd.ch   = req.char_code;
        cmd.attr = req.color;

        // Saturate the cursor to the screen.
        if (32'(req.cursor_x) > tcw_pkg::SCREEN_WIDTH - 1)
        begin
            cmd.col = tcw_pkg::COL_W'(tcw_pkg::SCREEN_WIDTH - 1);
        end
        else
        begin
            cmd.col = tcw_pkg::COL_W'(req.cursor_x);
        end
        if (32'(req.cursor_y) > tcw_pkg::SCREEN_HEIGHT - 1)
        begin
            row_sat = tcw_pkg::ROW_W'(tcw_pkg::SCREEN_HEIGHT - 1);
        end
        else
        begin
            row_sat = tcw_pkg::ROW_W'(req.cursor_y);
        end
        cmd.row_start = tcw_pkg::ADDR_W'(32'(row_sat) * tcw_pkg::SCREEN_WIDTH);

        cmd.raddr = tcw_pkg::ADDR_W'(req.read_offset);
        cmd.rd_ok = 32'(req.read_offset) < tcw_pkg::NUM_CELLS;

        unique case (tcw_pkg::func_t'(req.func))
            tcw_pkg::FUNC_PUT:
            begin
                if (req.char_code == tcw_pkg::CODE_NEWLINE)
                begin
                    cmd.op = tcw_pkg::OP_NEWLINE;
                end
                else if (req.char_code == tcw_pkg::CODE_TAB)
                begin
                    cmd.op = tcw_pkg::OP_TAB;
                end
                else
                begin
                    cmd.op = tcw_pkg::OP_CHAR;
                end
            end
            tcw_pkg::FUNC_SET:   cmd.op = tcw_pkg::OP_SET;
            tcw_pkg::FUNC_CLEAR: cmd.op = tcw_pkg::OP_CLEAR;
            tcw_pkg::FUNC_READ:  cmd.op = tcw_pkg::OP_READ;
        endcase
    end

    assign push.valid = req.valid && req.ready;
    assign push.cmd   = cmd;

endmodule

[design/tcw_cmd_queue.sv]
// Short command queue between the front end and the execution back end.
// Depends on tcw_pkg.
module tcw_cmd_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tcw_pkg::cmd_slot_t      push,
    input  logic                    pop,
    output logic                    full,
    output tcw_pkg::cmd_slot_t      head
);

    tcw_pkg::cmd_t                  slots_reg [tcw_pkg::Q_DEPTH];
    logic [tcw_pkg::Q_PTR_W-1:0]    wr_ptr_reg;
    logic [tcw_pkg::Q_PTR_W-1:0]    wr_ptr_next;
    logic [tcw_pkg::Q_PTR_W-1:0]    rd_ptr_reg;
    logic [tcw_pkg::Q_PTR_W-1:0]    rd_ptr_next;
    logic [tcw_pkg::Q_CNT_W-1:0]    count_reg;
    logic [tcw_pkg::Q_CNT_W-1:0]    count_next;
    logic                           do_push;
    logic                           do_pop;

    assign full       = count_reg == tcw_pkg::Q_CNT_W'(tcw_pkg::Q_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.cmd   = slots_reg[rd_ptr_reg];

    assign do_push = push.valid && !full;
    assign do_pop  = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == tcw_pkg::Q_DEPTH - 1) ? '0
                        : wr_ptr_reg + tcw_pkg::Q_PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == tcw_pkg::Q_DEPTH - 1) ? '0
                        : rd_ptr_reg + tcw_pkg::Q_PTR_W'(1);
        end
        count_next = count_reg + tcw_pkg::Q_CNT_W'(do_push) - tcw_pkg::Q_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

[design/tcw_back.sv]
// Back end: owns the print offset and the screen store, executes commands,
// runs the scroll, clear and reset sweeps and holds the response register.
// Depends on tcw_pkg, tcw_out_if and tcw_ram.
module tcw_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tcw_pkg::cmd_slot_t      head,
    output logic                    pop,
    output tcw_pkg::back_status_t   status,
    tcw_out_if.source               rsp
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_COPY,
        S_FILL
    } state_t;

    localparam int A = tcw_pkg::ADDR_W;
    localparam int S = tcw_pkg::SUM_W;
    localparam int C = tcw_pkg::COL_W;

    state_t                         state_reg, state_next;
    logic [A-1:0]                   off_reg, off_next;
    logic [C-1:0]                   col_reg, col_next;
    logic [A-1:0]                   row_start_reg, row_start_next;
    logic [A-1:0]                   cnt_reg, cnt_next;
    logic [tcw_pkg::CELL_W-1:0]     fill_data_reg, fill_data_next;
    logic                           scroll_reg, scroll_next;
    logic                           rd_ok_reg, rd_ok_next;
    logic                           out_valid_reg, out_valid_next;
    logic [tcw_pkg::POS_W-1:0]      out_pos_reg, out_pos_next;
    logic [tcw_pkg::CHAR_W-1:0]     out_char_reg, out_char_next;
    logic [tcw_pkg::ATTR_W-1:0]     out_attr_reg, out_attr_next;
    logic                           out_scrolled_reg, out_scrolled_next;

    logic                           ram_we;
    logic [A-1:0]                   ram_waddr;
    logic [tcw_pkg::CELL_W-1:0]     ram_wdata;
    logic [A-1:0]                   ram_raddr;
    logic [tcw_pkg::CELL_W-1:0]     ram_rdata;

    logic [S-1:0]                   phase;
    logic [S-1:0]                   delta;
    logic [S-1:0]                   off_sum;
    logic [S-1:0]                   col_sum;
    logic                           wrap;
    logic                           overflow;
    logic                           out_free;

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (tcw_pkg::NUM_CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign status.init_busy = state_reg == S_INIT;
    assign out_free = !out_valid_reg || rsp.ready;

    // Advance of the print offset for a put.
    always_comb
    begin
        phase = S'(off_reg % tcw_pkg::TAB_STOP);
        if (head.cmd.op == tcw_pkg::OP_NEWLINE)
        begin
            delta = S'(tcw_pkg::SCREEN_WIDTH) - S'(col_reg);
        end
        else if (head.cmd.op == tcw_pkg::OP_TAB)
        begin
            delta = S'(tcw_pkg::TAB_STOP) - phase;
        end
        else
        begin
            delta = S'(1);
        end
        off_sum  = S'(off_reg) + delta;
        col_sum  = S'(col_reg) + delta;
        wrap     = col_sum >= S'(tcw_pkg::SCREEN_WIDTH);
        overflow = off_sum >= S'(tcw_pkg::NUM_CELLS);
    end

    always_comb
    begin
        state_next        = state_reg;
        off_next          = off_reg;
        col_next          = col_reg;
        row_start_next    = row_start_reg;
        cnt_next          = cnt_reg;
        fill_data_next    = fill_data_reg;
        scroll_next       = scroll_reg;
        rd_ok_next        = rd_ok_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        out_pos_next      = out_pos_reg;
        out_char_next     = out_char_reg;
        out_attr_next     = out_attr_reg;
        out_scrolled_next = out_scrolled_reg;

        ram_we    = 1'b0;
        ram_waddr = cnt_reg;
        ram_wdata = fill_data_reg;
        ram_raddr = head.cmd.raddr;
        pop       = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (cnt_reg == A'(tcw_pkg::NUM_CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + A'(1);
                end
            end

            S_IDLE:
            begin
                if (head.valid && out_free)
                begin
                    pop = 1'b1;
                    unique case (head.cmd.op)
                        tcw_pkg::OP_CHAR, tcw_pkg::OP_NEWLINE, tcw_pkg::OP_TAB:
                        begin
                            if (head.cmd.op == tcw_pkg::OP_CHAR)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = off_reg;
                                ram_wdata = {head.cmd.attr, head.cmd.ch};
                            end
                            if (overflow)
                            begin
                                off_next       = A'(tcw_pkg::LAST_ROW);
                                col_next       = '0;
                                row_start_next = A'(tcw_pkg::LAST_ROW);
                                cnt_next       = '0;
                                fill_data_next = {head.cmd.attr, tcw_pkg::CODE_SPACE};
                                scroll_next    = 1'b1;
                                state_next     = S_COPY;
                            end
                            else
                            begin
                                off_next = A'(off_sum);
                                if (wrap)
                                begin
                                    col_next       = C'(col_sum - S'(tcw_pkg::SCREEN_WIDTH));
                                    row_start_next = row_start_reg
                                                   + A'(tcw_pkg::SCREEN_WIDTH);
                                end
                                else
                                begin
                                    col_next = C'(col_sum);
                                end
                                out_valid_next    = 1'b1;
                                out_pos_next      = tcw_pkg::POS_W'(off_sum);
                                out_char_next     = '0;
                                out_attr_next     = '0;
                                out_scrolled_next = 1'b0;
                            end
                        end

                        tcw_pkg::OP_SET:
                        begin
                            off_next          = head.cmd.row_start + A'(head.cmd.col);
                            col_next          = head.cmd.col;
                            row_start_next    = head.cmd.row_start;
                            out_valid_next    = 1'b1;
                            out_pos_next      = tcw_pkg::POS_W'(head.cmd.row_start
                                                                + A'(head.cmd.col));
                            out_char_next     = '0;
                            out_attr_next     = '0;
                            out_scrolled_next = 1'b0;
                        end

                        tcw_pkg::OP_CLEAR:
                        begin
                            off_next       = '0;
                            col_next       = '0;
                            row_start_next = '0;
                            cnt_next       = '0;
                            fill_data_next = {head.cmd.attr, tcw_pkg::CODE_SPACE};
                            scroll_next    = 1'b0;
                            state_next     = S_FILL;
                        end

                        tcw_pkg::OP_READ:
                        begin
                            ram_raddr  = head.cmd.raddr;
                            rd_ok_next = head.cmd.rd_ok;
                            state_next = S_READ;
                        end

                        default:
                        begin
                            out_valid_next    = 1'b1;
                            out_pos_next      = tcw_pkg::POS_W'(off_reg);
                            out_char_next     = '0;
                            out_attr_next     = '0;
                            out_scrolled_next = 1'b0;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                out_valid_next    = 1'b1;
                out_pos_next      = tcw_pkg::POS_W'(off_reg);
                out_char_next     = rd_ok_reg ? ram_rdata[tcw_pkg::CHAR_W-1:0] : '0;
                out_attr_next     = rd_ok_reg ? ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W]
                                              : '0;
                out_scrolled_next = 1'b0;
                state_next        = S_IDLE;
            end

            S_COPY:
            begin
                // Read one row ahead, write the cell read in the previous cycle.
                ram_raddr = cnt_reg + A'(tcw_pkg::SCREEN_WIDTH);
                if (cnt_reg != '0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_reg - A'(1);
                    ram_wdata = ram_rdata;
                end
                if (cnt_reg == A'(tcw_pkg::LAST_ROW))
                begin
                    state_next = S_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + A'(1);
                end
            end

            S_FILL:
            begin
                ram_we = 1'b1;
                if (cnt_reg == A'(tcw_pkg::NUM_CELLS - 1))
                begin
                    out_valid_next    = 1'b1;
                    out_pos_next      = tcw_pkg::POS_W'(off_reg);
                    out_char_next     = '0;
                    out_attr_next     = '0;
                    out_scrolled_next = scroll_reg;
                    state_next        = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + A'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_INIT;
            off_reg          <= '0;
            col_reg          <= '0;
            row_start_reg    <= '0;
            cnt_reg          <= '0;
            fill_data_reg    <= '0;
            scroll_reg       <= 1'b0;
            rd_ok_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_pos_reg      <= '0;
            out_char_reg     <= '0;
            out_attr_reg     <= '0;
            out_scrolled_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            off_reg          <= off_next;
            col_reg          <= col_next;
            row_start_reg    <= row_start_next;
            cnt_reg          <= cnt_next;
            fill_data_reg    <= fill_data_next;
            scroll_reg       <= scroll_next;
            rd_ok_reg        <= rd_ok_next;
            out_valid_reg    <= out_valid_next;
            out_pos_reg      <= out_pos_next;
            out_char_reg     <= out_char_next;
            out_attr_reg     <= out_attr_next;
            out_scrolled_reg <= out_scrolled_next;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.cursor_position = out_pos_reg;
    assign rsp.read_char       = out_char_reg;
    assign rsp.read_attr       = out_attr_reg;
    assign rsp.scrolled        = out_scrolled_reg;

endmodule

[design/text_console_writer_core.sv]
// Text console writer: command front end, command queue and execution back end.
// Depends on tcw_pkg, tcw_if, tcw_front, tcw_cmd_queue and tcw_back.
//
// Usage:
//   req carries one operation per transfer (put character, set cursor, clear
//   screen, read cell); rsp returns exactly one result per request, in order,
//   with the print offset after the operation.
//   Put (plain, newline, tab) and set cursor: one request per cycle is
//   sustained while rsp is ready; the result is registered.
//   Read cell: an extra S_READ state for the registered screen store read.
//   Scroll: a put that runs past the screen end moves the rows up one cell a
//   cycle and refills the bottom row.
//   Clear screen: one cell a cycle.
//   The screen store has a single write port, which sets these rates.
//   Reset: the screen store is swept to zero, one cell a cycle;
//   req.ready stays low until the sweep is done.
//   When rsp stalls, the result register holds and the two-entry command
//   queue fills, after which req.ready drops.
module text_console_writer_core (
    input  logic        clk,
    input  logic        rst_n,
    tcw_in_if.sink      req,
    tcw_out_if.source   rsp
);

    tcw_pkg::cmd_slot_t      push;
    tcw_pkg::cmd_slot_t      head;
    tcw_pkg::back_status_t   back_status;
    logic                    queue_full;
    logic                    pop;

    tcw_front u_front (
        .req         (req),
        .queue_full  (queue_full),
        .back_status (back_status),
        .push        (push)
    );

    tcw_cmd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (queue_full),
        .head  (head)
    );

    tcw_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .status (back_status),
        .rsp    (rsp)
    );

endmodule

[design/tcw_checker.sv]
// Port-level checks of the text console writer, bound to the top level.
// Depends on tcw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tcw_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_ready,
    input  logic                        rsp_valid,
    input  logic                        rsp_ready,
    input  logic [tcw_pkg::POS_W-1:0]   cursor_position,
    input  logic [tcw_pkg::CHAR_W-1:0]  read_char,
    input  logic [tcw_pkg::ATTR_W-1:0]  read_attr,
    input  logic                        scrolled
);

    `TCW_ASSERT_CLK(a_init_blocks_req, $rose(rst_n) |-> !req_ready, "request taken during reset sweep")
    `TCW_ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")
    `TCW_ASSERT_RSP(a_pos_range, 32'(cursor_position) < tcw_pkg::NUM_CELLS, "offset off screen")
    `TCW_ASSERT_RSP(a_scroll_pos, !scrolled || 32'(cursor_position) == tcw_pkg::LAST_ROW, "scroll offset")
    `TCW_ASSERT_RSP(a_scroll_noread, !scrolled || (read_char == '0 && read_attr == '0), "scroll with cell data")

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .cursor_position (rsp.cursor_position),
    .read_char       (rsp.read_char),
    .read_attr       (rsp.read_attr),
    .scrolled        (rsp.scrolled)
);
